// ----- design/wblm_pkg.sv -----
package wblm_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int TIME_BITS    = 48;

    localparam int OP_W    = 2;
    localparam int WL_W    = 7;
    localparam int PCT_W   = 7;
    localparam int Q_W     = PCT_W;
    localparam int STEP_W  = $clog2(Q_W);
    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W  = CNT_W + 1;
    localparam int CMP_W   = (CNT_W > WL_W) ? CNT_W : WL_W;
    localparam int REC_W   = TIME_BITS + 1;
    localparam int SUM_W   = TIME_BITS + $clog2(WINDOW_DEPTH);
    localparam int BUSY_W  = SUM_W + 1;
    localparam int TOT_W   = SUM_W + 2;
    localparam int NUM_W   = TOT_W + Q_W - 1;
    localparam int TDATA_W = ((TIME_BITS + 7) / 8) * 8;
    localparam int MDATA_W = ((PCT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0]  OP_IDLE  = 2'd0;
    localparam logic [OP_W-1:0]  OP_BUSY  = 2'd1;
    localparam logic [OP_W-1:0]  OP_QUERY = 2'd2;

    localparam logic [WL_W-1:0]  WL_RESET = 7'd64;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

    typedef struct packed {
        logic push_idle;
        logic push_busy;
        logic query;
        logic rd_en;
        logic evict;
        logic write;
        logic q_sum;
        logic div_init;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_evict;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- design/wblm_ram.sv -----
module wblm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ----- design/wblm_datapath.sv -----
module wblm_datapath import wblm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output ctrl_sts_t             sts,
    input  logic [TIME_BITS-1:0]  in_time,
    input  logic                  cfg_we,
    input  logic [WL_W-1:0]       cfg_wdata,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [PCT_W-1:0]      out_pct
);

    logic [WL_W-1:0]      wl_reg, wl_next;
    logic                 is_idle_reg, is_idle_next;
    logic [TIME_BITS-1:0] idle_start_reg, idle_start_next;
    logic [TIME_BITS-1:0] busy_start_reg, busy_start_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     idle_sum_reg, idle_sum_next;
    logic [SUM_W-1:0]     busy_sum_reg, busy_sum_next;
    logic                 out_valid_reg, out_valid_next;

    logic [TIME_BITS-1:0] dur_reg, dur_next;
    logic                 rec_idle_reg, rec_idle_next;
    logic [TIME_BITS-1:0] open_reg, open_next;
    logic [BUSY_W-1:0]    qbusy_reg, qbusy_next;
    logic [BUSY_W-1:0]    qidle_reg, qidle_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     dsr_reg, dsr_next;
    logic [Q_W-1:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [PCT_W-1:0]     out_pct_reg, out_pct_next;

    logic [CMP_W-1:0]     eff_len;
    logic [IDX_W-1:0]     head_inc;
    logic [SLOT_W-1:0]    slot_sum;
    logic [SLOT_W-1:0]    slot_wrap;
    logic [IDX_W-1:0]     slot;
    logic [REC_W-1:0]     rd_data;
    logic [TIME_BITS-1:0] old_dur;
    logic                 old_idle;
    logic [TOT_W-1:0]     tot_sum;
    logic [PCT_W-1:0]     pct_final;

    wblm_ram #(
        .WIDTH (REC_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk   (aclk),
        .we    (cmd.write),
        .waddr (slot),
        .wdata ({rec_idle_reg, dur_reg}),
        .re    (cmd.rd_en),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    assign old_dur  = rd_data[TIME_BITS-1:0];
    assign old_idle = rd_data[TIME_BITS];

    always_comb begin
        if (wl_reg == '0) begin
            eff_len = CMP_W'(1);
        end else if (CMP_W'(wl_reg) > CMP_W'(WINDOW_DEPTH)) begin
            eff_len = CMP_W'(WINDOW_DEPTH);
        end else begin
            eff_len = CMP_W'(wl_reg);
        end
    end

    assign head_inc  = (head_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign slot_sum  = SLOT_W'(head_reg) + SLOT_W'(count_reg);
    assign slot_wrap = (slot_sum >= SLOT_W'(WINDOW_DEPTH)) ?
                       slot_sum - SLOT_W'(WINDOW_DEPTH) : slot_sum;
    assign slot      = slot_wrap[IDX_W-1:0];
    assign tot_sum   = TOT_W'(qbusy_reg) + TOT_W'(qidle_reg);
    assign pct_final = (total_reg == '0) ? '0 :
                       (quo_reg > PCT_MAX) ? PCT_MAX : quo_reg;

    always_comb begin
        wl_next         = wl_reg;
        is_idle_next    = is_idle_reg;
        idle_start_next = idle_start_reg;
        busy_start_next = busy_start_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idle_sum_next   = idle_sum_reg;
        busy_sum_next   = busy_sum_reg;
        out_valid_next  = out_valid_reg;
        dur_next        = dur_reg;
        rec_idle_next   = rec_idle_reg;
        open_next       = open_reg;
        qbusy_next      = qbusy_reg;
        qidle_next      = qidle_reg;
        total_next      = total_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        out_pct_next    = out_pct_reg;

        if (cfg_we) begin
            wl_next = cfg_wdata;
        end
        if (cmd.push_idle) begin
            dur_next        = in_time - busy_start_reg;
            rec_idle_next   = 1'b0;
            is_idle_next    = 1'b1;
            idle_start_next = in_time;
        end
        if (cmd.push_busy) begin
            dur_next        = in_time - idle_start_reg;
            rec_idle_next   = 1'b1;
            is_idle_next    = 1'b0;
            busy_start_next = in_time;
        end
        if (cmd.query) begin
            open_next = in_time - (is_idle_reg ? idle_start_reg : busy_start_reg);
        end
        if (cmd.evict) begin
            if (old_idle) begin
                idle_sum_next = idle_sum_reg - SUM_W'(old_dur);
            end else begin
                busy_sum_next = busy_sum_reg - SUM_W'(old_dur);
            end
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        if (cmd.write) begin
            if (rec_idle_reg) begin
                idle_sum_next = idle_sum_reg + SUM_W'(dur_reg);
            end else begin
                busy_sum_next = busy_sum_reg + SUM_W'(dur_reg);
            end
            count_next = count_reg + 1'b1;
        end
        if (cmd.q_sum) begin
            qbusy_next = BUSY_W'(busy_sum_reg) + (is_idle_reg ? '0 : BUSY_W'(open_reg));
            qidle_next = BUSY_W'(idle_sum_reg) + (is_idle_reg ? BUSY_W'(open_reg) : '0);
        end
        if (cmd.div_init) begin
            total_next = tot_sum;
            rem_next   = NUM_W'(qbusy_reg) * NUM_W'(PCT_MAX);
            dsr_next   = NUM_W'(tot_sum) << (Q_W - 1);
            quo_next   = '0;
            step_next  = '0;
        end
        if (cmd.div_step) begin
            if (rem_reg >= dsr_reg) begin
                rem_next = rem_reg - dsr_reg;
                quo_next = {quo_reg[Q_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[Q_W-2:0], 1'b0};
            end
            dsr_next  = dsr_reg >> 1;
            step_next = step_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_pct_next   = pct_final;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg         <= WL_RESET;
            is_idle_reg    <= 1'b0;
            idle_start_reg <= '0;
            busy_start_reg <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            idle_sum_reg   <= '0;
            busy_sum_reg   <= '0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
        end else begin
            wl_reg         <= wl_next;
            is_idle_reg    <= is_idle_next;
            idle_start_reg <= idle_start_next;
            busy_start_reg <= busy_start_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idle_sum_reg   <= idle_sum_next;
            busy_sum_reg   <= busy_sum_next;
            out_valid_reg  <= out_valid_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dur_reg      <= dur_next;
        rec_idle_reg <= rec_idle_next;
        open_reg     <= open_next;
        qbusy_reg    <= qbusy_next;
        qidle_reg    <= qidle_next;
        total_reg    <= total_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        quo_reg      <= quo_next;
        out_pct_reg  <= out_pct_next;
    end

    assign sts.need_evict = CMP_W'(count_reg) >= eff_len;
    assign sts.div_last   = (step_reg == STEP_W'(Q_W - 1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_pct   = out_pct_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("record count above window depth");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> (CMP_W'(count_reg) < CMP_W'(WINDOW_DEPTH)))
        else $error("record written into a full window");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_pct_reg <= PCT_MAX))
        else $error("load percent above 100");

endmodule

// ----- design/wblm_ctrl.sv -----
module wblm_ctrl import wblm_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [OP_W-1:0] in_op,
    output logic            in_ready,
    output ctrl_cmd_t       cmd,
    input  ctrl_sts_t       sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVICT = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_QSUM  = 3'd3;
    localparam logic [2:0] ST_QTOT  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_op)
                        OP_IDLE, OP_BUSY: begin
                            cmd.push_idle = (in_op == OP_IDLE);
                            cmd.push_busy = (in_op == OP_BUSY);
                            if (sts.need_evict) begin
                                cmd.rd_en  = 1'b1;
                                state_next = ST_EVICT;
                            end else begin
                                state_next = ST_WRITE;
                            end
                        end
                        OP_QUERY: begin
                            cmd.query  = 1'b1;
                            state_next = ST_QSUM;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EVICT: begin
                cmd.evict  = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_QSUM: begin
                cmd.q_sum  = 1'b1;
                state_next = ST_QTOT;
            end
            ST_QTOT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_read_then_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> cmd.evict)
        else $error("eviction does not follow history read");

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.evict, cmd.write, cmd.q_sum, cmd.div_init, cmd.div_step,
                  cmd.out_load, in_ready}))
        else $error("more than one datapath action at once");

    a_evict_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |=> cmd.write)
        else $error("eviction not followed by record write");

endmodule

// ----- design/windowed_busy_load_meter_unit.sv -----
// Busy-load meter over a sliding window of phase records.
// Input stream: s_tuser carries the operation (start idle, start busy, query),
// s_tdata the timestamp in microseconds. A phase start records the length of
// the phase just ended into a history memory of WINDOW_DEPTH entries and keeps
// running busy and idle sums; the oldest record drops out once the window
// holds window_length records. A query adds the open phase and returns
// 100*busy/(busy+idle), truncated, on the m_ channel; other items give none.
// A phase start goes to the write state, via an evict state when a record is
// evicted (one history memory read). A query passes the sum, total, 7-step
// restoring divider and output states. The next item is accepted the cycle
// after the result is loaded into the output register, so a stalled receiver
// holds back only the following query. The user must write window_length via
// cfg_we only while the block is idle; the block does not enforce it. Reset
// (aresetn low, synchronous) clears sums, counts, start times and the output
// valid, and sets window_length to 64; no memory clearing is needed.
module windowed_busy_load_meter_unit import wblm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // time_us
    input  logic [OP_W-1:0]    s_tuser,   // op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,   // load_percent, zero fill
    input  logic               cfg_we,
    input  logic [WL_W-1:0]    cfg_wdata
);

    ctrl_cmd_t        cmd;
    ctrl_sts_t        sts;
    logic [PCT_W-1:0] pct;

    wblm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    wblm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_time   (s_tdata[TIME_BITS-1:0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_pct   (pct)
    );

    assign m_tdata = MDATA_W'(pct);

endmodule
